// ----- src/tlpq_pkg.sv -----
package tlpq_pkg;

   // Queue geometry
   localparam int NUM_LEVELS  = 3;
   localparam int LEVEL_DEPTH = 8;
   localparam int TASK_WIDTH  = 32;

   // Field widths fixed by the interface
   localparam int TASK_FIELD_W = 32;
   localparam int PRI_W        = 2;
   localparam int STATUS_W     = 2;

   // Derived widths
   localparam int STORE_W = (TASK_WIDTH < TASK_FIELD_W) ? TASK_WIDTH : TASK_FIELD_W;
   localparam int PTR_W   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
   localparam int LVL_W   = $clog2(NUM_LEVELS);

   // Operation codes
   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPRI = 2'd3;

   typedef struct packed {
      logic                    operation;
      logic [TASK_FIELD_W-1:0] task_value;
      logic [PRI_W-1:0]        priority_level;
   } req_type;

   typedef struct packed {
      logic [TASK_FIELD_W-1:0] task_out;
      logic [STATUS_W-1:0]     status;
      logic                    all_empty;
      logic                    any_full;
   } rsp_type;

   // Controller states
   typedef enum logic {
      CS_IDLE,
      CS_READ
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;      // request transfer happens this cycle
      logic load_read;   // move store read data into the result register
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_busy;    // result register holds a result not taken this cycle
      logic deq_hit;     // pending request is a dequeue that finds a task
   } dp_stat_type;

endpackage

// ----- src/tlpq_ctrl.sv -----
module tlpq_ctrl
   import tlpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid && !dp_stat.out_busy && dp_stat.deq_hit) begin
               state_in = CS_READ;
            end
         end
         CS_READ: begin
            state_in = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready        = 1'b0;
      dp_cmd.accept    = 1'b0;
      dp_cmd.load_read = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready     = !dp_stat.out_busy;
            dp_cmd.accept = req_valid && !dp_stat.out_busy;
         end
         CS_READ: begin
            dp_cmd.load_read = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/tlpq_dp.sv -----
module tlpq_dp
   import tlpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_cmd_type  dp_cmd,
   output dp_stat_type dp_stat,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   // Task store, one row per level
   logic [STORE_W-1:0] mem [NUM_LEVELS][LEVEL_DEPTH];
   logic [STORE_W-1:0] rd_data_ff;

   // Per-level FIFO control
   logic [PTR_W-1:0] head_ff [NUM_LEVELS];
   logic [PTR_W-1:0] head_in [NUM_LEVELS];
   logic [PTR_W-1:0] tail_ff [NUM_LEVELS];
   logic [PTR_W-1:0] tail_in [NUM_LEVELS];
   logic [CNT_W-1:0] cnt_ff  [NUM_LEVELS];
   logic [CNT_W-1:0] cnt_in  [NUM_LEVELS];

   // Result register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [TASK_FIELD_W-1:0] task_out_ff;
   logic [STATUS_W-1:0]     status_ff;
   logic                    all_empty_ff;
   logic                    any_full_ff;

   logic [LVL_W-1:0]    enq_lvl;
   logic [LVL_W-1:0]    deq_lvl;
   logic                deq_found;
   logic                is_enq;
   logic                bad_pri;
   logic                lvl_full;
   logic                enq_ok;
   logic                deq_ok;
   logic [STATUS_W-1:0] status_next;
   logic                all_empty_next;
   logic                any_full_next;

   // Pick the highest non-empty level for a dequeue
   always_comb begin
      deq_found = 1'b1;
      deq_lvl   = LVL_W'(2);
      priority if (cnt_ff[2] != '0) begin
         deq_lvl = LVL_W'(2);
      end else if (cnt_ff[1] != '0) begin
         deq_lvl = LVL_W'(1);
      end else if (cnt_ff[0] != '0) begin
         deq_lvl = LVL_W'(0);
      end else begin
         deq_found = 1'b0;
      end
   end

   // Decode the pending request
   always_comb begin
      is_enq   = (req_data.operation == OP_ENQ);
      enq_lvl  = LVL_W'(req_data.priority_level) - LVL_W'(1);
      bad_pri  = (req_data.priority_level == '0);
      lvl_full = !bad_pri && (cnt_ff[enq_lvl] == CNT_W'(LEVEL_DEPTH));
      enq_ok   = is_enq && !bad_pri && !lvl_full;
      deq_ok   = !is_enq && deq_found;

      priority if (is_enq && bad_pri) begin
         status_next = ST_BADPRI;
      end else if (is_enq && lvl_full) begin
         status_next = ST_FULL;
      end else if (!is_enq && !deq_found) begin
         status_next = ST_EMPTY;
      end else begin
         status_next = ST_OK;
      end
   end

   // Advance pointers and counts on a transfer that changes the queue
   always_comb begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
         cnt_in[i]  = cnt_ff[i];
      end
      if (dp_cmd.accept && enq_ok) begin
         tail_in[enq_lvl] = (tail_ff[enq_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ? '0 :
                            tail_ff[enq_lvl] + PTR_W'(1);
         cnt_in[enq_lvl]  = cnt_ff[enq_lvl] + CNT_W'(1);
      end
      if (dp_cmd.accept && deq_ok) begin
         head_in[deq_lvl] = (head_ff[deq_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ? '0 :
                            head_ff[deq_lvl] + PTR_W'(1);
         cnt_in[deq_lvl]  = cnt_ff[deq_lvl] - CNT_W'(1);
      end
   end

   // Queue flags after the step
   always_comb begin
      all_empty_next = 1'b1;
      any_full_next  = 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (cnt_in[i] != '0) begin
            all_empty_next = 1'b0;
         end
         if (cnt_in[i] == CNT_W'(LEVEL_DEPTH)) begin
            any_full_next = 1'b1;
         end
      end
   end

   // Result valid: set on a finished result, drop when taken
   always_comb begin
      priority if (dp_cmd.load_read) begin
         rsp_valid_in = 1'b1;
      end else if (dp_cmd.accept && !deq_ok) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= head_in[i];
            tail_ff[i] <= tail_in[i];
            cnt_ff[i]  <= cnt_in[i];
         end
      end
   end

   // Task store: write on enqueue, registered read on dequeue
   always_ff @(posedge clock) begin
      if (dp_cmd.accept && enq_ok) begin
         mem[enq_lvl][tail_ff[enq_lvl]] <= req_data.task_value[STORE_W-1:0];
      end
      if (dp_cmd.accept && deq_ok) begin
         rd_data_ff <= mem[deq_lvl][head_ff[deq_lvl]];
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (dp_cmd.accept) begin
         task_out_ff  <= '0;
         status_ff    <= status_next;
         all_empty_ff <= all_empty_next;
         any_full_ff  <= any_full_next;
      end
      if (dp_cmd.load_read) begin
         task_out_ff <= TASK_FIELD_W'(rd_data_ff);
      end
   end

   assign dp_stat.out_busy   = rsp_valid_ff && !rsp_ready;
   assign dp_stat.deq_hit    = deq_ok;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data.task_out  = task_out_ff;
   assign rsp_data.status    = status_ff;
   assign rsp_data.all_empty = all_empty_ff;
   assign rsp_data.any_full  = any_full_ff;

endmodule

// ----- src/three_level_priority_queue_top.sv -----
// Three-level strict-priority task queue.
// Requests arrive on req_valid/req_ready with req_data: an enqueue puts
// task_value into the FIFO of priority_level (1 to 3), a dequeue returns the
// oldest task of the highest non-empty level. Each request gives exactly one
// result on rsp_valid/rsp_ready with rsp_data: task word, status (ok, level
// full, queue empty, bad priority) and the empty/full flags after the step.
// Results: an enqueue, a rejected request or an empty dequeue has its result
// in the cycle after the transfer; a dequeue that finds a task is read through
// the registered store port first and then loaded into the result register.
// Enqueues are taken at one request per cycle while the receiver takes each
// result; a dequeue that returns a task drops req_ready during the store read.
// A result waits in the output register; a new request is taken while that
// result is transferred in the same cycle. If the receiver stalls, req_ready
// drops until the held result is taken.
// Reset empties all three levels at once; store contents need no clearing.
module three_level_priority_queue_top
   import tlpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // Sequence request transfers and store reads
   tlpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   // Hold the FIFOs and the result register
   tlpq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
